// ===== hdl/rlfe_pkg.sv =====
// shared types, constants and the bit-to-nibble expansion for the led frame encoder
package rlfe_pkg;

  localparam int DutyW      = 16;
  localparam int GainW      = 5;
  localparam int CodeW      = 2;
  localparam int LineWordW  = 32;
  localparam int FrameWords = 14;
  localparam int MaxWords   = 32;
  localparam int ResetBytes = 128;
  localparam int WordCntW   = $clog2(MaxWords);
  localparam int ByteIdxW   = $clog2(FrameWords);
  localparam int CmdDepth   = 2;
  localparam int CmdPtrW    = $clog2(CmdDepth);

  localparam int ResetWordsRaw = (ResetBytes + 3) / 4;
  localparam int ResetWords    = (ResetWordsRaw > MaxWords) ? MaxWords :
                                 ((ResetWordsRaw == 0) ? 1 : ResetWordsRaw);
  localparam logic [WordCntW-1:0] LastResetIdx = WordCntW'(ResetWords - 1);
  localparam logic [ByteIdxW-1:0] LastFrameIdx = ByteIdxW'(FrameWords - 1);

  localparam logic [4:0] ReserveBits = 5'h1F;
  localparam logic [3:0] NibbleZero  = 4'h8;
  localparam logic [3:0] NibbleOne   = 4'hE;

  // register indexes on the configuration port
  localparam int PaddrW = 4;
  localparam logic [1:0] RegGain   = 2'd0;
  localparam logic [1:0] RegSleep  = 2'd1;
  localparam logic [1:0] RegNormal = 2'd2;

  typedef struct packed {
    logic             mode;
    logic [DutyW-1:0] red_duty;
    logic [DutyW-1:0] green_duty;
    logic [DutyW-1:0] blue_duty;
    logic [DutyW-1:0] white_duty;
    logic [DutyW-1:0] yellow_duty;
  } in_word_t;

  typedef struct packed {
    logic [LineWordW-1:0] line_word;
    logic                 last_word;
    logic                 pause_after;
  } out_word_t;

  typedef struct packed {
    logic [GainW-1:0] current_gain;
    logic [CodeW-1:0] sleep_code;
    logic [CodeW-1:0] normal_code;
  } cfg_t;

  // element FrameWords-1 holds the first byte on the line
  typedef struct packed {
    logic                           burst;
    logic                           two_copies;
    logic [FrameWords-1:0][7:0]     frame;
  } cmd_t;

  function automatic logic [LineWordW-1:0] expand_byte(input logic [7:0] b);
    logic [LineWordW-1:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      w[4*i +: 4] = b[i] ? NibbleOne : NibbleZero;
    end
    return w;
  endfunction

endpackage

// ===== hdl/rgbwy_led_frame_encoder_unit.sv =====
// top level of the rgbwy led frame encoder: config registers, front end, queue, back end
// Each accepted item turns into line words out of the word sequencer: a colour frame
// is 14 words, a frame that wakes the driver from sleep is sent twice (28 words), and
// a reset burst is 32 zero words. Items are taken in back to back into a two-entry
// command queue, so the input stalls only when the queue is full; the sustained rate
// is set by the sequencer, one output word per cycle while pop keeps up. The last word
// of each item carries last_word, and the first copy of a wake frame ends with
// pause_after. Configuration (gain, sleep and normal codes) sits at byte addresses 0,
// 4 and 8; the user must write it only while idle, which the block does not enforce.
module rgbwy_led_frame_encoder_unit import rlfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  in_word_t          in_word_i,
  output logic              empty,
  input  logic              pop,
  output out_word_t         out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg_q, cfg_d;
  logic cfg_wr;
  logic cmd_push, cmd_pop, cmd_full, cmd_valid;
  cmd_t cmd_in, cmd_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        RegGain:   cfg_d.current_gain = pwdata[GainW-1:0];
        RegSleep:  cfg_d.sleep_code   = pwdata[CodeW-1:0];
        RegNormal: cfg_d.normal_code  = pwdata[CodeW-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegGain:   prdata = 32'(cfg_q.current_gain);
      RegSleep:  prdata = 32'(cfg_q.sleep_code);
      RegNormal: prdata = 32'(cfg_q.normal_code);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_gain <= '0;
      cfg_q.sleep_code   <= '0;
      cfg_q.normal_code  <= CodeW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign full = cmd_full;

  rlfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (in_word_i),
    .cfg_i      (cfg_q),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  rlfe_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_push),
    .wdata_i (cmd_in),
    .rd_i    (cmd_pop),
    .rdata_o (cmd_out),
    .full_o  (cmd_full),
    .valid_o (cmd_valid)
  );

  rlfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== hdl/rlfe_front.sv =====
// front end: takes items, picks the standby code and repeat count, builds the frame
module rlfe_front import rlfe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_word_t item_i,
  input  cfg_t     cfg_i,
  input  logic     cmd_full_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  logic [CodeW-1:0] prev_standby_q, prev_standby_d;
  logic             known_q, known_d;
  logic [CodeW-1:0] standby;
  logic [LineWordW-1:0] ctrl;
  logic             all_zero;
  logic [GainW-1:0] g;

  assign cmd_push_o = push_i && !cmd_full_i;

  always_comb begin
    all_zero = (item_i.red_duty | item_i.green_duty | item_i.blue_duty |
                item_i.white_duty | item_i.yellow_duty) == '0;
    standby  = all_zero ? cfg_i.sleep_code : cfg_i.normal_code;
    g        = cfg_i.current_gain;
    ctrl     = {g, g, g, g, g, standby, ReserveBits};

    cmd_o.burst      = item_i.mode;
    cmd_o.two_copies = known_q && (prev_standby_q != standby) &&
                       (prev_standby_q == cfg_i.sleep_code);
    cmd_o.frame      = {item_i.red_duty, item_i.green_duty, item_i.blue_duty,
                        item_i.white_duty, item_i.yellow_duty, ctrl};

    prev_standby_d = prev_standby_q;
    known_d        = known_q;
    // reset bursts leave the standby history alone
    if (cmd_push_o && !item_i.mode) begin
      prev_standby_d = standby;
      known_d        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_standby_q <= '0;
      known_q        <= 1'b0;
    end else begin
      prev_standby_q <= prev_standby_d;
      known_q        <= known_d;
    end
  end

endmodule

// ===== hdl/rlfe_cmd_fifo.sv =====
// two-entry command queue between the front end and the word sequencer
module rlfe_cmd_fifo import rlfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wdata_i,
  input  logic rd_i,
  output cmd_t rdata_o,
  output logic full_o,
  output logic valid_o
);

  cmd_t                 mem_q [CmdDepth];
  logic [CmdPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [CmdPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CmdPtrW:0]     count_q, count_d;
  logic                 do_wr, do_rd;

  assign full_o  = count_q == (CmdPtrW+1)'(CmdDepth);
  assign valid_o = count_q != '0;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/rlfe_back.sv =====
// back end: walks one command word by word into the output register
module rlfe_back import rlfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_word_t out_word_o
);

  logic [WordCntW-1:0] idx_q, idx_d;
  logic                copy_q, copy_d;
  logic                out_valid_q, out_valid_d;
  out_word_t           out_q, out_d;
  logic                advance;
  logic [ByteIdxW-1:0] byte_sel;
  logic                frame_end;

  assign empty_o    = !out_valid_q;
  assign out_word_o = out_q;
  assign advance    = cmd_valid_i && (!out_valid_q || pop_i);
  assign byte_sel   = LastFrameIdx - idx_q[ByteIdxW-1:0];
  assign frame_end  = idx_q[ByteIdxW-1:0] == LastFrameIdx;

  always_comb begin
    idx_d       = idx_q;
    copy_d      = copy_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    cmd_pop_o   = 1'b0;
    if (out_valid_q && pop_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d       = 1'b1;
      out_d.pause_after = 1'b0;
      out_d.last_word   = 1'b0;
      idx_d             = idx_q + 1'b1;
      if (cmd_i.burst) begin
        out_d.line_word = '0;
        if (idx_q == LastResetIdx) begin
          out_d.last_word = 1'b1;
          cmd_pop_o       = 1'b1;
          idx_d           = '0;
        end
      end else begin
        out_d.line_word = expand_byte(cmd_i.frame[byte_sel]);
        if (frame_end) begin
          idx_d = '0;
          if (cmd_i.two_copies && !copy_q) begin
            // first copy of a wake frame: line pauses, then the repeat
            out_d.pause_after = 1'b1;
            copy_d            = 1'b1;
          end else begin
            out_d.last_word = 1'b1;
            copy_d          = 1'b0;
            cmd_pop_o       = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      copy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      copy_q      <= copy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule
